// ===== design/utf8sd_pkg.sv =====
// utf8sd_pkg: types, constants and lead-byte helpers for the utf-8 stream decoder
// used by the front, queue and back modules; depends on nothing else
package utf8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned BUF_N  = 4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // one decode decision handed from the front to the back
  typedef struct packed {
    logic              repl;
    logic [2:0]        len;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic              last;
  } cmd_t;

  // form length from a lead byte: 1..4, 0 for a bad lead
  function automatic logic [2:0] form_length(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // true when the buffer gives no further result until more bytes arrive
  function automatic logic run_idle(input logic [BYTE_W-1:0] head,
                                    input logic [2:0] cnt,
                                    input logic eot);
    logic [2:0] len;
    len = form_length(head);
    return (cnt == 3'd0) || (!eot && (len != 3'd0) && (len > cnt));
  endfunction

endpackage

// ===== design/utf8_stream_decoder_top.sv =====
// utf8_stream_decoder_top: streaming utf-8 to code point decoder. A byte whose transfer
// causes at most one result is taken every cycle; a byte that causes k results (bad leads,
// bad continuations rerun as leads, a form cut short at end of text) holds the input until
// all k are made, as the front's classify step makes one decision per cycle. Each
// decision waits in a QUEUE_DEPTH-entry queue and leaves it through a registered output;
// a full queue stalls the input. Overlong forms are accepted, and the pending buffer
// empties after the end-of-text byte.
// depends on utf8sd_pkg, utf8sd_front, utf8sd_queue and utf8sd_back
module utf8_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tuser,  // is_replacement
  output logic        out_tlast   // last_of_run
);
  import utf8sd_pkg::*;

  logic            push_valid, q_full, q_pop, q_empty;
  cmd_t            push_cmd, q_head;
  logic [CP_W-1:0] code_point;

  utf8sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_eot     (in_tlast),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  utf8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head_cmd   (q_head)
  );

  utf8sd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_code_point (code_point),
    .out_is_repl    (out_tuser),
    .out_last       (out_tlast)
  );

  assign out_tdata = {3'b000, code_point};

endmodule

// ===== design/utf8sd_front.sv =====
// utf8sd_front: takes input bytes into the pending buffer, classifies the head form
// and pushes one decision per cycle while the queue has room; depends on utf8sd_pkg
module utf8sd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_eot,
  output logic                     push_valid,
  output utf8sd_pkg::cmd_t         push_cmd,
  input  logic                     q_full
);
  import utf8sd_pkg::*;

  logic [BYTE_W-1:0] buf_r   [BUF_N];
  logic [BYTE_W-1:0] buf_nxt [BUF_N];
  logic [2:0]        cnt_r, cnt_nxt;
  logic              eot_r, eot_nxt;

  logic [BYTE_W-1:0] vb [BUF_N];
  logic [BYTE_W-1:0] nb [BUF_N];
  logic [2:0]        vcnt, ncnt, lead_len, drop, idx;
  logic              veot, accept, emit, repl, flush, cont_ok, too_big, surrogate;
  logic              commit;

  always_comb begin
    in_ready = run_idle(buf_r[0], cnt_r, eot_r) && !q_full;
    accept   = in_valid && in_ready;

    // view of the buffer with the incoming byte appended
    vb   = buf_r;
    vcnt = cnt_r;
    veot = eot_r;
    if (accept) begin
      vb[cnt_r[1:0]] = in_byte;
      vcnt           = cnt_r + 3'd1;
      veot           = in_eot;
    end

    lead_len  = form_length(vb[0]);
    cont_ok   = ((lead_len < 3'd2) || (vb[1][7:6] == 2'b10)) &&
                ((lead_len < 3'd3) || (vb[2][7:6] == 2'b10)) &&
                ((lead_len < 3'd4) || (vb[3][7:6] == 2'b10));
    // above 0x10ffff: bits 20:16 of the four-byte value exceed 0x10
    too_big   = (lead_len == 3'd4) && ({vb[0][2:0], vb[1][5:4]} > 5'b10000);
    // surrogate range: bits 20:11 of the value are 0000011011, also for
    // overlong four-byte forms
    surrogate = ((lead_len == 3'd3) && (vb[0][3:0] == 4'hD) && vb[1][5]) ||
                ((lead_len == 3'd4) && (vb[0][2:0] == 3'd0) &&
                 (vb[1][5:0] == 6'h0D) && vb[2][5]);

    emit  = 1'b0;
    repl  = 1'b0;
    flush = 1'b0;
    drop  = 3'd0;
    if (vcnt != 3'd0) begin
      if (lead_len == 3'd0) begin
        emit = 1'b1;
        repl = 1'b1;
        drop = 3'd1;
      end else if (lead_len > vcnt) begin
        // form cut short by end of text drops everything
        if (veot) begin
          emit  = 1'b1;
          repl  = 1'b1;
          flush = 1'b1;
        end
      end else if (cont_ok && !too_big && !surrogate) begin
        emit = 1'b1;
        drop = lead_len;
      end else begin
        emit = 1'b1;
        repl = 1'b1;
        drop = 3'd1;
      end
    end

    for (int i = 0; i < BUF_N; i++) begin
      idx   = 3'(i) + drop;
      nb[i] = (idx < 3'd4) ? vb[idx[1:0]] : vb[i];
    end
    ncnt = flush ? 3'd0 : (vcnt - drop);

    commit     = !emit || !q_full;
    push_valid = emit && !q_full;

    push_cmd.repl = repl;
    push_cmd.len  = lead_len;
    push_cmd.b0   = vb[0];
    push_cmd.b1   = vb[1];
    push_cmd.b2   = vb[2];
    push_cmd.b3   = vb[3];
    push_cmd.last = run_idle(nb[0], ncnt, veot);

    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    eot_nxt = eot_r;
    if (commit) begin
      buf_nxt = nb;
      cnt_nxt = ncnt;
      eot_nxt = veot;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      eot_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      eot_r <= eot_nxt;
    end
  end

endmodule

// ===== design/utf8sd_queue.sv =====
// utf8sd_queue: short first-in first-out queue of decode decisions between
// the front and the back; depends on utf8sd_pkg
module utf8sd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  utf8sd_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output utf8sd_pkg::cmd_t head_cmd
);
  import utf8sd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    full     = (cnt_r == CW'(DEPTH));
    empty    = (cnt_r == '0);
    head_cmd = mem_r[rd_ptr_r];
    do_push  = push_valid && !full;
    do_pop   = pop && !empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/utf8sd_back.sv =====
// utf8sd_back: assembles code points from queued decode decisions into the
// output register; depends on utf8sd_pkg
module utf8sd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  utf8sd_pkg::cmd_t            q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8sd_pkg::CP_W-1:0] out_code_point,
  output logic                        out_is_repl,
  output logic                        out_last
);
  import utf8sd_pkg::*;

  logic            valid_r, valid_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            repl_r, last_r;
  logic [CP_W-1:0] code;

  always_comb begin
    case (q_head.len)
      3'd1:    code = {14'd0, q_head.b0[6:0]};
      3'd2:    code = {10'd0, q_head.b0[4:0], q_head.b1[5:0]};
      3'd3:    code = {5'd0, q_head.b0[3:0], q_head.b1[5:0], q_head.b2[5:0]};
      3'd4:    code = {q_head.b0[2:0], q_head.b1[5:0], q_head.b2[5:0], q_head.b3[5:0]};
      default: code = REPL_CP;
    endcase
    cp_nxt = q_head.repl ? REPL_CP : code;

    // output register frees up when empty or when its transfer completes
    q_pop     = !q_empty && (!valid_r || out_ready);
    valid_nxt = q_pop || (valid_r && !out_ready);

    out_valid      = valid_r;
    out_code_point = cp_r;
    out_is_repl    = repl_r;
    out_last       = last_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cp_r   <= cp_nxt;
      repl_r <= q_head.repl;
      last_r <= q_head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== tb/sv/utf8_point_checker.sv =====
// utf8_point_checker: watches the byte and code point channels of the utf-8 stream decoder,
// predicts the code points each accepted byte causes and compares them in order
// standalone; hands its mismatch count and the number of code points still owed to the tb top
module utf8_point_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  input  logic        out_tuser,  // is_replacement
  input  logic        out_tlast,  // last_of_run
  output int          mismatches,
  output int          owed_points
);

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [31:0] MAX_SCALAR  = 32'h0010FFFF;
  localparam logic [31:0] SURR_LO     = 32'h0000D800;
  localparam logic [31:0] SURR_HI     = 32'h0000DFFF;
  localparam int          MAX_PRINTED = 50;

  typedef struct packed {
    logic [20:0] code;
    logic        repl;
    logic        last;
  } code_point_t;

  code_point_t expected_points[$];

  // byte buffer of the predictor, head first
  logic [7:0]  held_bytes [0:3];
  int unsigned held_cnt;

  initial begin
    mismatches  = 0;
    owed_points = 0;
    held_cnt    = 0;
  end

  function automatic int unsigned lead_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic void drop_held(input int unsigned k);
    int unsigned i;
    for (i = 0; i + k < 4; i++) begin
      held_bytes[i] = held_bytes[i + k];
    end
    held_cnt = held_cnt - k;
  endfunction

  // run one accepted byte through the decoder and queue the code points it gives
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    code_point_t run [0:3];
    int          n;
    int unsigned len;
    int unsigned i;
    logic [31:0] acc;
    logic        ok;
    logic [7:0]  c;
    n = 0;
    if (held_cnt > 3) held_cnt = 3;
    held_bytes[held_cnt] = b;
    held_cnt++;
    while (held_cnt > 0) begin
      len = lead_length(held_bytes[0]);
      if (len == 0) begin
        if (n < 4) begin
          run[n] = '{REPLACEMENT, 1'b1, 1'b0};
          n++;
        end
        drop_held(1);
      end else if (len > held_cnt) begin
        // form cut short at end of text: one replacement, the rest is dropped
        if (eot) begin
          if (n < 4) begin
            run[n] = '{REPLACEMENT, 1'b1, 1'b0};
            n++;
          end
          held_cnt = 0;
        end
        break;
      end else begin
        acc = (len == 1) ? {24'd0, held_bytes[0]} : {24'd0, held_bytes[0] & (8'h7F >> len)};
        ok  = 1'b1;
        for (i = 1; i < len; i++) begin
          c = held_bytes[i];
          if (c[7:6] != 2'b10) ok = 1'b0;
          acc = (acc << 6) | {26'd0, c[5:0]};
        end
        if (ok && acc <= MAX_SCALAR && !(acc >= SURR_LO && acc <= SURR_HI)) begin
          if (n < 4) begin
            run[n] = '{acc[20:0], 1'b0, 1'b0};
            n++;
          end
          drop_held(len);
        end else begin
          // only the lead goes, the bytes after it are tried again as leads
          if (n < 4) begin
            run[n] = '{REPLACEMENT, 1'b1, 1'b0};
            n++;
          end
          drop_held(1);
        end
      end
    end
    if (eot) held_cnt = 0;
    if (n > 0) run[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_points.insert(expected_points.size(), run[k]);
  endtask

  always @(posedge clk) begin
    code_point_t want;
    if (rst_n) begin
      if (out_tvalid === 1'b1 && out_tready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("code point %h with none expected", out_tdata));
        end else begin
          want = expected_points.pop_front();
          if (out_tdata !== {3'b000, want.code}) begin
            report_mismatch($sformatf("code_point %h, expected %h", out_tdata, want.code));
          end
          if (out_tuser !== want.repl) begin
            report_mismatch($sformatf("is_replacement %b, expected %b", out_tuser, want.repl));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("last_of_run %b, expected %b", out_tlast, want.last));
          end
        end
      end
      if (in_tvalid && in_tready === 1'b1) begin
        decode_byte(in_tdata, in_tlast);
      end
      owed_points = expected_points.size();
    end
  end

endmodule

// ===== tb/sv/utf8_stream_decoder_top_tb.sv =====
// utf8_stream_decoder_top_tb: drives utf-8 text bytes into utf8_stream_decoder_top with
// random gaps and output stalls; checking is done by utf8_point_checker, instantiated here
module utf8_stream_decoder_top_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] zero
  logic        out_tuser;  // is_replacement
  logic        out_tlast;  // last_of_run

  int mismatches;
  int owed_points;
  int idle_pct;
  int byte_total;

  // directed text: {end_of_text, byte}
  logic [8:0] opening [0:26] = '{
    9'h000, 9'h07F,                   // ascii extremes
    9'h0C2, 9'h0A9,                   // two-byte form
    9'h0E2, 9'h082, 9'h0AC,           // three-byte form
    9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte form
    9'h0F4, 9'h090, 9'h080, 9'h080,   // above 0x10ffff, tail rerun as leads
    9'h0ED, 9'h0A0, 9'h080,           // surrogate
    9'h0C0, 9'h080,                   // overlong, accepted
    9'h0FF,                           // bad lead
    9'h0E2, 9'h041,                   // bad continuation
    9'h0E2, 9'h182,                   // cut short at end of text
    9'h0F0, 9'h141                    // cut short, dropped tail holds a bad continuation
  };

  utf8_stream_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_point_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .owed_points (owed_points)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[utf8_stream_decoder_top] ERROR");
    $finish;
  end

  // result side: random stall bursts while idling is on
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_pct == 0) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    byte_total++;
  endtask

  // one character, mostly well formed with random payload, sometimes noise or broken
  task automatic send_char();
    logic [7:0] seq [0:3];
    int         len;
    int         n;
    int         flavor;
    logic       eot;
    len = $urandom_range(1, 4);
    case (len)
      1:       seq[0] = 8'($urandom_range(0, 127));
      2:       seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
      3:       seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
      default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    for (int i = 1; i < 4; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
    n = len;
    flavor = $urandom_range(0, 99);
    if (flavor < 7) begin
      seq[0] = 8'($urandom_range(0, 255));
      n = 1;
    end else if (flavor < 14 && len > 1) begin
      n = $urandom_range(1, len - 1);
    end else if (flavor < 21 && len > 1) begin
      seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    end
    eot = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) send_byte(seq[i], eot && (i == n - 1));
  endtask

  initial begin : stimulus
    bit drained_once;
    drained_once = 1'b0;
    idle_pct   = 25;
    byte_total = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

    // hold off until every pending code point has come out
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_points != 0) @(posedge clk);

    while (byte_total < 220) begin
      if (byte_total >= 185) begin
        idle_pct = 0;
      end else if ((byte_total / 40) % 3 == 1) begin
        idle_pct = 0;
      end else begin
        idle_pct = 30;
      end
      if (!drained_once && byte_total >= 130) begin
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_points != 0) @(posedge clk);
      end
      send_char();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (owed_points != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[utf8_stream_decoder_top] OK");
    end else begin
      $display("[utf8_stream_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
